FILE: rtl/bti_pkg.sv
// Package for the bilinear table interpolator.
// Holds sizes, codes, the sequencer state type and small helper functions.
// Depends on nothing.
package bti_pkg;

  localparam int MAX_X_POINTS = 16;
  localparam int MAX_Y_POINTS = 16;
  localparam int GRID_DEPTH   = 256;
  localparam int BP_AW        = $clog2(MAX_X_POINTS);
  localparam int GRID_AW      = $clog2(GRID_DEPTH);
  localparam int PTS_W        = 5;
  localparam int DATA_W       = 32;
  localparam int DIFF_W       = DATA_W + 1;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = 98;
  localparam int DEN_W        = PROD_W;
  localparam int DIV_STEPS    = ACC_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FUNC_WR_X    = 2'd0,
    FUNC_WR_Y    = 2'd1,
    FUNC_WR_GRID = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    CFG_X_POINTS = 1'b0,
    CFG_Y_POINTS = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SX, S_SY, S_LD1, S_LD2, S_CHK, S_DMUL, S_GRD,
    S_M1, S_M2, S_M3, S_M4, S_DIV, S_DIVW, S_RES
  } state_e;

  // Point counts below two act as two, above the maximum as the maximum.
  function automatic logic [PTS_W-1:0] clamp_pts(input logic [PTS_W-1:0] v,
                                                 input logic [PTS_W-1:0] mx);
    logic [PTS_W-1:0] r;
    r = v;
    if (v < PTS_W'(2)) r = PTS_W'(2);
    else if (v > mx) r = mx;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[DATA_W-1:0] : v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag_data(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] n;
    n = -v;
    return v[DATA_W-1] ? n : v;
  endfunction

endpackage

FILE: rtl/bti_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses bti_pkg for widths. The remainder also yields the round-half-up flag.
module bti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bti_pkg::ACC_W-1:0]   num_i,
  input  logic [bti_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [bti_pkg::ACC_W-1:0]   quo_o,
  output logic                        round_up_o
);

  logic                              busy_q, done_q;
  logic [bti_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [bti_pkg::ACC_W-1:0]         nq_q, nq_d;
  logic [bti_pkg::DEN_W-1:0]         rem_q, rem_d, den_q;
  logic [bti_pkg::DEN_W:0]           sh, diff;
  logic                              ge, last;

  always_comb begin
    sh   = {rem_q, nq_q[bti_pkg::ACC_W-1]};
    diff = sh - {1'b0, den_q};
    ge   = sh >= {1'b0, den_q};
    rem_d = ge ? diff[bti_pkg::DEN_W-1:0] : sh[bti_pkg::DEN_W-1:0];
    nq_d  = {nq_q[bti_pkg::ACC_W-2:0], ge};
    last  = cnt_q == bti_pkg::DIV_CNT_W'(bti_pkg::DIV_STEPS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= nq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quo_o      = nq_q;
  assign round_up_o = {rem_q, 1'b0} >= {1'b0, den_q};

endmodule

FILE: rtl/bilinear_table_interp_core.sv
// Bilinear table interpolator: a query scans each axis's breakpoints, then forms the
// grid products and divides, or goes straight to the result on a zero-width cell.
// One item is worked on at a time; writes and queries are taken only when idle.
// Query time is set by the one-bit-per-cycle divider, the single 32x32 multiplier
// and the one-entry-per-cycle breakpoint scan. Asynchronous active-low reset
// clears control state; the tables are undefined until written.
module bilinear_table_interp_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [7:0]               entry_index_i,
  input  logic signed [31:0]       entry_value_i,
  input  logic signed [31:0]       query_x_i,
  input  logic signed [31:0]       query_y_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       interpolated_value_o,
  output logic                     saturated_o,
  output logic                     zero_width_cell_o,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [4:0]               cfg_data_i
);

  localparam int DW = bti_pkg::DATA_W;
  localparam int AW = bti_pkg::BP_AW;
  localparam int GW = bti_pkg::GRID_AW;
  localparam int PW = bti_pkg::PTS_W;
  localparam int CW = bti_pkg::ACC_W;

  bti_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [PW-1:0] cfg_x_q, cfg_y_q, nx, ny;

  // Breakpoint tables are small flop arrays read combinationally at the scan index and
  // at both cell corners; the grid is a memory with a registered read port.
  logic signed [DW-1:0] xbp_q [bti_pkg::MAX_X_POINTS];
  logic signed [DW-1:0] ybp_q [bti_pkg::MAX_Y_POINTS];
  logic signed [DW-1:0] grid_q [bti_pkg::GRID_DEPTH];
  logic signed [DW-1:0] rdata_q;
  logic [GW-1:0]        raddr;

  logic                 in_xfer, out_load;
  logic signed [DW-1:0] qx_q, qy_q, x1_q, x2_q, y1_q, y2_q;

  // Search state; the scan registers are shared by both axes, i_q holds the x cell, j_q the y cell.
  logic [AW-1:0]        k_q, i_q, j_q, cell_q, final_cell;
  logic                 first_le_q, found_q, prev_lt_q;
  logic                 axis_y, lt, eq, hit, last;
  logic signed [DW-1:0] cmp_a, cmp_b;
  logic [PW-1:0]        n_cur;

  // Arithmetic datapath.
  logic signed [bti_pkg::DIFF_W-1:0] wx, wy, a_sel, b_sel;
  logic [DW-1:0]                     mul_a, mul_b, phi_q;
  logic [bti_pkg::PROD_W-1:0]        prod_q;
  logic [bti_pkg::DEN_W-1:0]         d_q;
  logic [1:0]                        t_q;
  logic [GW-1:0]                     base_q;
  logic [GW:0]                       base_c;
  logic signed [CW-1:0]              acc_q, part;
  logic                              tneg_q, zw_q, rneg_q;

  logic                              div_start, div_done, round_up;
  logic [CW-1:0]                     div_num, quo, qr;
  logic [DW-1:0]                     limit, res_mag, res_val;
  logic                              res_sat;

  assign nx = bti_pkg::clamp_pts(cfg_x_q, PW'(bti_pkg::MAX_X_POINTS));
  assign ny = bti_pkg::clamp_pts(cfg_y_q, PW'(bti_pkg::MAX_Y_POINTS));
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_load = (state_q == bti_pkg::S_RES) && (!out_valid_o || out_ready_i);

  // Shared comparator for the breakpoint scan.
  always_comb begin
    axis_y = state_q == bti_pkg::S_SY;
    n_cur  = axis_y ? ny : nx;
    cmp_a  = axis_y ? qy_q : qx_q;
    cmp_b  = axis_y ? ybp_q[k_q] : xbp_q[k_q];
    lt     = cmp_a < cmp_b;
    eq     = cmp_a == cmp_b;
    last   = {1'b0, k_q} == n_cur - PW'(1);
    hit    = (k_q != '0) && !found_q && !prev_lt_q && lt;
    if (first_le_q)   final_cell = '0;
    else if (!lt)     final_cell = AW'(n_cur - PW'(2));
    else if (found_q) final_cell = cell_q;
    else if (hit)     final_cell = k_q - 1'b1;
    else              final_cell = '0;
  end

  // Cell widths and corner distances; t_q bit 0 picks the upper x corner,
  // bit 1 the upper y corner.
  always_comb begin
    wx    = {x2_q[DW-1], x2_q} - {x1_q[DW-1], x1_q};
    wy    = {y2_q[DW-1], y2_q} - {y1_q[DW-1], y1_q};
    a_sel = t_q[0] ? ({qx_q[DW-1], qx_q} - {x1_q[DW-1], x1_q})
                   : ({x2_q[DW-1], x2_q} - {qx_q[DW-1], qx_q});
    b_sel = t_q[1] ? ({qy_q[DW-1], qy_q} - {y1_q[DW-1], y1_q})
                   : ({y2_q[DW-1], y2_q} - {qy_q[DW-1], qy_q});
    base_c = (GW+1)'({{(GW+1-AW){1'b0}}, i_q} * {{(GW+1-PW){1'b0}}, ny})
           + (GW+1)'(j_q);
    raddr  = base_q + (t_q[0] ? GW'(ny) : GW'(0)) + GW'(t_q[1]);
    part   = tneg_q ? -$signed(CW'(prod_q)) : $signed(CW'(prod_q));
    div_num = acc_q[CW-1] ? CW'(-acc_q) : CW'(acc_q);
  end

  // Rounding and saturation of the quotient.
  always_comb begin
    qr      = quo + CW'(round_up);
    limit   = rneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    res_sat = qr > CW'(limit);
    res_mag = res_sat ? limit : qr[DW-1:0];
    res_val = rneg_q ? -res_mag : res_mag;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bti_pkg::S_IDLE:
        if (in_xfer && func_i == bti_pkg::FUNC_QUERY) state_d = bti_pkg::S_SX;
      bti_pkg::S_SX:   if (last) state_d = bti_pkg::S_SY;
      bti_pkg::S_SY:   if (last) state_d = bti_pkg::S_LD1;
      bti_pkg::S_LD1:  state_d = bti_pkg::S_LD2;
      bti_pkg::S_LD2:  state_d = bti_pkg::S_CHK;
      bti_pkg::S_CHK:
        state_d = (wx == '0 || wy == '0) ? bti_pkg::S_RES : bti_pkg::S_DMUL;
      bti_pkg::S_DMUL: state_d = bti_pkg::S_GRD;
      bti_pkg::S_GRD:  state_d = bti_pkg::S_M1;
      bti_pkg::S_M1:   state_d = bti_pkg::S_M2;
      bti_pkg::S_M2:   state_d = bti_pkg::S_M3;
      bti_pkg::S_M3:   state_d = bti_pkg::S_M4;
      bti_pkg::S_M4:   state_d = (t_q == 2'd3) ? bti_pkg::S_DIV : bti_pkg::S_GRD;
      bti_pkg::S_DIV:  state_d = bti_pkg::S_DIVW;
      bti_pkg::S_DIVW: if (div_done) state_d = bti_pkg::S_RES;
      bti_pkg::S_RES:  if (out_load) state_d = bti_pkg::S_IDLE;
      default:         state_d = bti_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and divider start.
  always_comb begin
    in_ready_o = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state_q)
      bti_pkg::S_IDLE: in_ready_o = 1'b1;
      bti_pkg::S_DMUL: begin
        mul_a = bti_pkg::mag_diff(wx);
        mul_b = bti_pkg::mag_diff(wy);
      end
      bti_pkg::S_M1: begin
        mul_a = bti_pkg::mag_data(rdata_q);
        mul_b = bti_pkg::mag_diff(a_sel);
      end
      bti_pkg::S_M2: begin
        mul_a = prod_q[DW-1:0];
        mul_b = bti_pkg::mag_diff(b_sel);
      end
      bti_pkg::S_M3: begin
        mul_a = phi_q;
        mul_b = bti_pkg::mag_diff(b_sel);
      end
      bti_pkg::S_DIV: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bti_pkg::S_IDLE;
      cfg_x_q     <= PW'(bti_pkg::MAX_X_POINTS);
      cfg_y_q     <= PW'(bti_pkg::MAX_Y_POINTS);
      out_valid_o <= 1'b0;
      k_q         <= '0;
      t_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bti_pkg::CFG_X_POINTS: cfg_x_q <= cfg_data_i;
          bti_pkg::CFG_Y_POINTS: cfg_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      if (state_q == bti_pkg::S_SX || state_q == bti_pkg::S_SY) begin
        k_q <= last ? '0 : k_q + 1'b1;
      end
      if (state_q == bti_pkg::S_CHK) t_q <= '0;
      else if (state_q == bti_pkg::S_M4) t_q <= t_q + 1'b1;
    end
  end

  // Table writes and the registered grid read.
  always_ff @(posedge clk_i) begin
    if (in_xfer && func_i == bti_pkg::FUNC_WR_X &&
        entry_index_i < 8'(bti_pkg::MAX_X_POINTS))
      xbp_q[entry_index_i[AW-1:0]] <= entry_value_i;
    if (in_xfer && func_i == bti_pkg::FUNC_WR_Y &&
        entry_index_i < 8'(bti_pkg::MAX_Y_POINTS))
      ybp_q[entry_index_i[AW-1:0]] <= entry_value_i;
    if (in_xfer && func_i == bti_pkg::FUNC_WR_GRID)
      grid_q[entry_index_i[GW-1:0]] <= entry_value_i;
    rdata_q <= grid_q[raddr];
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_xfer) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
    end
    if (state_q == bti_pkg::S_SX || state_q == bti_pkg::S_SY) begin
      prev_lt_q <= lt;
      if (k_q == '0) begin
        first_le_q <= lt || eq;
        found_q    <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
        cell_q  <= k_q - 1'b1;
      end
      if (last && !axis_y) i_q <= final_cell;
      if (last && axis_y)  j_q <= final_cell;
    end
    if (state_q == bti_pkg::S_LD1) begin
      x1_q <= xbp_q[i_q];
      y1_q <= ybp_q[j_q];
    end
    if (state_q == bti_pkg::S_LD2) begin
      x2_q <= xbp_q[i_q + 1'b1];
      y2_q <= ybp_q[j_q + 1'b1];
    end
    if (state_q == bti_pkg::S_CHK) begin
      zw_q   <= (wx == '0) || (wy == '0);
      acc_q  <= '0;
      base_q <= base_c[GW-1:0];
    end
    if (state_q == bti_pkg::S_GRD && t_q == '0) d_q <= prod_q;
    if (state_q == bti_pkg::S_M1) tneg_q <= rdata_q[DW-1] ^ a_sel[DW] ^ b_sel[DW];
    if (state_q == bti_pkg::S_M2) phi_q <= prod_q[bti_pkg::PROD_W-1:DW];
    if (state_q == bti_pkg::S_M3) acc_q <= acc_q + part;
    if (state_q == bti_pkg::S_M4) acc_q <= acc_q + (part <<< DW);
    if (state_q == bti_pkg::S_DIV) rneg_q <= acc_q[CW-1] ^ wx[DW] ^ wy[DW];
    if (out_load) begin
      interpolated_value_o <= zw_q ? '0 : res_val;
      saturated_o          <= zw_q ? 1'b0 : res_sat;
      zero_width_cell_o    <= zw_q;
    end
  end

  bti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (div_num),
    .den_i      (d_q),
    .done_o     (div_done),
    .quo_o      (quo),
    .round_up_o (round_up)
  );

  a_zero_width_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_width_cell_o |-> interpolated_value_o == '0 && !saturated_o)
    else $error("zero-width result carries a value or a saturation flag");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      interpolated_value_o == 32'sh7FFF_FFFF || interpolated_value_o == 32'sh8000_0000)
    else $error("saturated result is not at a range limit");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bti_pkg::S_SX |-> {1'b0, k_q} < nx)
    else $error("x breakpoint scan ran past the points in use");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bti_pkg::S_DIVW)
    else $error("divider finished while the sequencer was not waiting for it");

endmodule
